>>> design/adaptive_bin_weight_histogram_core_defines.svh
// Assertion macros shared by the histogram block.
`ifndef ADAPTIVE_BIN_WEIGHT_HISTOGRAM_CORE_DEFINES_SVH
`define ADAPTIVE_BIN_WEIGHT_HISTOGRAM_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ABWH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ABWH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/abwh_pkg.sv
package abwh_pkg;

  localparam int NUM_BINS     = 10;
  localparam int MAX_CHANNELS = 16;
  localparam int MAX_DIMS     = 8;

  localparam int CH_W     = 4;
  localparam int DIM_W    = 3;
  localparam int BIN_W    = 4;
  localparam int COORD_W  = 16;
  localparam int COUNT_W  = 16;
  localparam int WEIGHT_W = 17;

  localparam int STORE_DEPTH = MAX_CHANNELS * MAX_DIMS * NUM_BINS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int DIV_STEPS = COUNT_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic load;       // capture an accepted item
    logic clr_start;  // clear event counts and restart the sweep counter
    logic clr_step;   // zero one bin-store entry
    logic mem_rd;     // read the bin store at the item address
    logic exec;       // update counts or set up the division
    logic div_step;   // one quotient bit
    logic out_load;   // move the result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_read;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> design/abwh_ctrl.sv
module abwh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              start_batch,
  output logic              in_stall,
  output abwh_pkg::dp_cmd_t cmd,
  input  abwh_pkg::dp_stat_t stat
);
  import abwh_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EXEC,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;
  logic   pending;

  logic accept;
  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    cmd.clr_start = accept && start_batch;
    cmd.clr_step  = (state == S_CLEAR);
    cmd.mem_rd    = (state == S_RD);
    cmd.exec      = (state == S_EXEC);
    cmd.div_step  = (state == S_DIV);
    cmd.out_load  = (state == S_DONE) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      pending <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (stat.clr_last) begin
            state   <= pending ? S_RD : S_IDLE;
            pending <= 1'b0;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (start_batch) begin
              state   <= S_CLEAR;
              pending <= 1'b1;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= stat.is_read ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (stat.div_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/abwh_datapath.sv
module abwh_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  abwh_pkg::dp_cmd_t                      cmd,
  output abwh_pkg::dp_stat_t                     stat,
  input  logic                                   req_type,
  input  logic [abwh_pkg::CH_W-1:0]              channel,
  input  logic [abwh_pkg::DIM_W-1:0]             dim,
  input  logic [abwh_pkg::COORD_W-1:0]           coord,
  input  logic                                   accepted,
  input  logic                                   end_of_event,
  input  logic [abwh_pkg::BIN_W-1:0]             bin,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [abwh_pkg::WEIGHT_W-1:0]          weight,
  output logic [abwh_pkg::COUNT_W-1:0]           raw_count,
  output logic                                   empty_channel
);
  import abwh_pkg::*;

  localparam int PROD_W = COORD_W + $clog2(NUM_BINS) + 1;
  localparam int IDX_W  = PROD_W - COORD_W;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
  endfunction

  // Captured item.
  logic               item_read;
  logic [CH_W-1:0]    item_channel;
  logic [DIM_W-1:0]   item_dim;
  logic [COORD_W-1:0] item_coord;
  logic               item_accepted;
  logic               item_eoe;
  logic [BIN_W-1:0]   item_bin;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_read     <= req_type;
      item_channel  <= channel;
      item_dim      <= dim;
      item_coord    <= coord;
      item_accepted <= accepted;
      item_eoe      <= end_of_event;
      item_bin      <= bin;
    end
  end

  logic ch_ok, dim_ok, bin_ok;
  assign ch_ok  = ({1'b0, item_channel} < (CH_W + 1)'(MAX_CHANNELS));
  assign dim_ok = ({1'b0, item_dim} < (DIM_W + 1)'(MAX_DIMS));
  assign bin_ok = ({1'b0, item_bin} < (BIN_W + 1)'(NUM_BINS));

  // Bin of a sample: floor(coord * NUM_BINS / 2^16), clamped to the last bin.
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  idx_raw;
  logic [BIN_W-1:0]  sample_bin;
  assign prod    = PROD_W'(item_coord) * PROD_W'(NUM_BINS);
  assign idx_raw = prod[PROD_W-1:COORD_W];
  assign sample_bin = (idx_raw > IDX_W'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1)
                                                       : BIN_W'(idx_raw);

  logic [BIN_W-1:0]  sel_bin;
  logic [ADDR_W-1:0] item_addr;
  assign sel_bin = item_read ? (bin_ok ? item_bin : '0) : sample_bin;
  assign item_addr = (ch_ok && dim_ok)
      ? ADDR_W'((32'(item_channel) * MAX_DIMS + 32'(item_dim)) * NUM_BINS
                + 32'(sel_bin))
      : '0;

  // Bin store and the sweep that clears it.
  logic [COUNT_W-1:0] mem [STORE_DEPTH];
  logic [COUNT_W-1:0] rd_data;
  logic [ADDR_W-1:0]  clr_cnt;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;
  logic               sample_upd;

  assign sample_upd = cmd.exec && !item_read && ch_ok && item_accepted;
  assign mem_we     = cmd.clr_step || (sample_upd && dim_ok);
  assign mem_waddr  = cmd.clr_step ? clr_cnt : item_addr;
  assign mem_wdata  = cmd.clr_step ? '0 : sat_inc(rd_data);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[item_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Event counts per channel.
  logic [COUNT_W-1:0] ev_cnt [MAX_CHANNELS];
  logic [COUNT_W-1:0] ev_sel;
  assign ev_sel = ch_ok ? ev_cnt[item_channel] : '0;

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        ev_cnt[i] <= '0;
      end
    end else if (sample_upd && item_eoe) begin
      ev_cnt[item_channel] <= sat_inc(ev_cnt[item_channel]);
    end
  end

  // Restoring divider: count * 2^16 / events, one quotient bit a cycle.
  // Its quotient is used only when count < events, so it fits in 16 bits.
  logic [COUNT_W-1:0] res_count;
  logic [COUNT_W-1:0] den;
  logic [COUNT_W:0]   rem;
  logic [COUNT_W-1:0] quot;
  logic               res_empty;
  logic               res_sat;
  logic [STEP_W-1:0]  step_cnt;
  logic [COUNT_W-1:0] cnt_v;
  logic [COUNT_W:0]   rem2;

  assign cnt_v = (ch_ok && dim_ok && bin_ok) ? rd_data : '0;
  assign rem2  = {rem[COUNT_W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.exec && item_read) begin
      res_count <= cnt_v;
      den       <= ev_sel;
      rem       <= {1'b0, cnt_v};
      quot      <= '0;
      res_empty <= (ev_sel == '0);
      res_sat   <= (cnt_v >= ev_sel);
    end else if (cmd.div_step) begin
      if (rem2 >= {1'b0, den}) begin
        rem  <= rem2 - {1'b0, den};
        quot <= {quot[COUNT_W-2:0], 1'b1};
      end else begin
        rem  <= rem2;
        quot <= {quot[COUNT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.exec) begin
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      step_cnt <= step_cnt + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      raw_count     <= res_count;
      empty_channel <= res_empty;
      if (res_empty) begin
        weight <= '0;
      end else if (res_sat) begin
        weight <= {1'b1, {COUNT_W{1'b0}}};
      end else begin
        weight <= {1'b0, quot};
      end
    end
  end

  always_comb begin
    stat          = '0;
    stat.clr_last = (clr_cnt == ADDR_W'(STORE_DEPTH - 1));
    stat.is_read  = item_read;
    stat.div_last = cmd.div_step && (step_cnt == STEP_W'(DIV_STEPS - 1));
    stat.out_free = !out_valid || !out_stall;
  end

endmodule

>>> design/adaptive_bin_weight_histogram_core.sv
// Per-channel, per-dimension histogram of accepted sample coordinates with
// a per-channel event count and a normalized bin weight readout.
// Input channel: in_valid / in_stall with one port per field. An accepted sample
// item (req_type 0) bumps its bin and, at the end of an event, the event count.
// A read item (req_type 1) gives one result on the output channel:
// raw_count, weight = count * 2^16 / events saturated at 1.0, empty_channel.
// One item is worked on at a time. A sample passes through a bin-store read,
// then a read-modify-write, before the next item is accepted. A read does
// the bin-store read, sets up the 16-step restoring divider and runs it; its
// result moves from the done state into the output register once that is free.
// A start_batch mark, and every reset, clears the event counts and all 1280
// bin-store entries, one entry a cycle, while in_stall stays high.
// While the receiver stalls, the result stays in the output register and the
// block still accepts new items; a read that finishes waits for the slot.
module adaptive_bin_weight_histogram_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   req_type,
  input  logic                                   start_batch,
  input  logic [abwh_pkg::CH_W-1:0]              channel,
  input  logic [abwh_pkg::DIM_W-1:0]             dim,
  input  logic [abwh_pkg::COORD_W-1:0]           coord,
  input  logic                                   accepted,
  input  logic                                   end_of_event,
  input  logic [abwh_pkg::BIN_W-1:0]             bin,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [abwh_pkg::WEIGHT_W-1:0]          weight,
  output logic [abwh_pkg::COUNT_W-1:0]           raw_count,
  output logic                                   empty_channel
);
  import abwh_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  abwh_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .start_batch (start_batch),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .stat        (stat)
  );

  abwh_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (req_type),
    .channel       (channel),
    .dim           (dim),
    .coord         (coord),
    .accepted      (accepted),
    .end_of_event  (end_of_event),
    .bin           (bin),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .weight        (weight),
    .raw_count     (raw_count),
    .empty_channel (empty_channel)
  );

`include "adaptive_bin_weight_histogram_core_defines.svh"

  `ABWH_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
    "block took a second item in the cycle after accepting one")
  `ABWH_ASSERT_NEXT(a_result_shown, cmd.out_load, out_valid,
    "result loaded but not presented")
  `ABWH_ASSERT_NOW(a_load_free_slot, cmd.out_load, stat.out_free,
    "result loaded over one that was not taken")
  `ABWH_ASSERT_NOW(a_weight_form, out_valid,
    (!empty_channel || weight == '0) && (!weight[COUNT_W] || weight[COUNT_W-1:0] == '0),
    "weight out of its range")

endmodule

>>> sim/adaptive_bin_weight_histogram_core_tb.sv
`timescale 1ns / 100ps

module adaptive_bin_weight_histogram_core_tb;
  import abwh_pkg::*;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_READ   = 1'b1
  } req_kind_t;

  typedef struct {
    req_kind_t           kind;
    logic                start_batch;
    logic [CH_W-1:0]     channel;
    logic [DIM_W-1:0]    dim;
    logic [COORD_W-1:0]  coord;
    logic                accepted;
    logic                end_of_event;
    logic [BIN_W-1:0]    bin;
  } hist_req_t;

  typedef struct {
    logic [WEIGHT_W-1:0] weight;
    logic [COUNT_W-1:0]  raw_count;
    logic                empty_channel;
  } bin_weight_t;

  localparam int COUNT_TOP     = 2**COUNT_W - 1;
  localparam longint WEIGHT_FULL = 2**COORD_W;
  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 60;
  localparam int ITEMS_PER_PHASE = 480;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                req_type = 1'b0;
  logic                start_batch = 1'b0;
  logic [CH_W-1:0]     channel = '0;
  logic [DIM_W-1:0]    dim = '0;
  logic [COORD_W-1:0]  coord = '0;
  logic                accepted = 1'b0;
  logic                end_of_event = 1'b0;
  logic [BIN_W-1:0]    bin = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [WEIGHT_W-1:0] weight;
  logic [COUNT_W-1:0]  raw_count;
  logic                empty_channel;

  // Mirror of the block's counts.
  logic [COUNT_W-1:0] bin_tally [STORE_DEPTH];
  logic [COUNT_W-1:0] event_tally [MAX_CHANNELS];
  bin_weight_t        weights_due [$];

  int errors = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  adaptive_bin_weight_histogram_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .start_batch   (start_batch),
    .channel       (channel),
    .dim           (dim),
    .coord         (coord),
    .accepted      (accepted),
    .end_of_event  (end_of_event),
    .bin           (bin),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .weight        (weight),
    .raw_count     (raw_count),
    .empty_channel (empty_channel)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int tally_slot(int ch, int d, int b);
    return (ch * MAX_DIMS + d) * NUM_BINS + b;
  endfunction

  function automatic logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
    return (v == COUNT_TOP) ? v : v + 1'b1;
  endfunction

  function automatic void clear_tallies();
    foreach (bin_tally[i]) bin_tally[i] = '0;
    foreach (event_tally[i]) event_tally[i] = '0;
  endfunction

  // Updates the mirrored counts for one item; returns 1 when a read result is due.
  function automatic bit histogram_update(hist_req_t r, output bin_weight_t w);
    int     b;
    int     count;
    int     events;
    longint q;
    w = '{weight: '0, raw_count: '0, empty_channel: 1'b0};
    if (r.start_batch) clear_tallies();
    if (r.kind == REQ_SAMPLE) begin
      if (r.channel >= MAX_CHANNELS || !r.accepted) return 0;
      b = (int'(r.coord) * NUM_BINS) >> COORD_W;
      if (b > NUM_BINS - 1) b = NUM_BINS - 1;
      if (r.dim < MAX_DIMS)
        bin_tally[tally_slot(int'(r.channel), int'(r.dim), b)] =
          bump(bin_tally[tally_slot(int'(r.channel), int'(r.dim), b)]);
      if (r.end_of_event) event_tally[r.channel] = bump(event_tally[r.channel]);
      return 0;
    end
    count = 0;
    events = 0;
    if (r.channel < MAX_CHANNELS) begin
      events = int'(event_tally[r.channel]);
      if (r.dim < MAX_DIMS && r.bin < NUM_BINS)
        count = int'(bin_tally[tally_slot(int'(r.channel), int'(r.dim), int'(r.bin))]);
    end
    w.raw_count = COUNT_W'(count);
    w.empty_channel = (events == 0);
    if (events != 0) begin
      q = (longint'(count) << COORD_W) / events;
      if (q > WEIGHT_FULL) q = WEIGHT_FULL;
      w.weight = WEIGHT_W'(q);
    end
    return 1;
  endfunction

  initial clear_tallies();

  // Prediction, result checking and the watchdog, all on the rising edge.
  always @(posedge clk) begin
    hist_req_t   r;
    bin_weight_t w;
    bin_weight_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        r.kind = req_kind_t'(req_type);
        r.start_batch = start_batch;
        r.channel = channel;
        r.dim = dim;
        r.coord = coord;
        r.accepted = accepted;
        r.end_of_event = end_of_event;
        r.bin = bin;
        if (histogram_update(r, w)) weights_due.push_back(w);
      end
      if (out_valid && !out_stall) begin
        if (weights_due.size() == 0) begin
          $error("unexpected result: weight %0d raw_count %0d empty_channel %0d",
                 weight, raw_count, empty_channel);
          errors++;
        end else begin
          want = weights_due.pop_front();
          if (weight !== want.weight) begin
            $error("weight: expected %0d, got %0d", want.weight, weight);
            errors++;
          end
          if (raw_count !== want.raw_count) begin
            $error("raw_count: expected %0d, got %0d", want.raw_count, raw_count);
            errors++;
          end
          if (empty_channel !== want.empty_channel) begin
            $error("empty_channel: expected %0d, got %0d", want.empty_channel,
                   empty_channel);
            errors++;
          end
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL adaptive_bin_weight_histogram_core");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic hist_req_t make_sample(logic [CH_W-1:0] ch, logic [DIM_W-1:0] d,
                                            logic [COORD_W-1:0] x, logic acc,
                                            logic eoe, logic sb);
    hist_req_t r;
    r.kind = REQ_SAMPLE;
    r.start_batch = sb;
    r.channel = ch;
    r.dim = d;
    r.coord = x;
    r.accepted = acc;
    r.end_of_event = eoe;
    r.bin = BIN_W'($urandom_range(2**BIN_W - 1));
    return r;
  endfunction

  function automatic hist_req_t make_read(logic [CH_W-1:0] ch, logic [DIM_W-1:0] d,
                                          logic [BIN_W-1:0] b, logic sb, logic eoe);
    hist_req_t r;
    r.kind = REQ_READ;
    r.start_batch = sb;
    r.channel = ch;
    r.dim = d;
    r.coord = COORD_W'($urandom_range(2**COORD_W - 1));
    r.accepted = 1'($urandom_range(1));
    r.end_of_event = eoe;
    r.bin = b;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input hist_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r.kind;
    start_batch <= r.start_batch;
    channel <= r.channel;
    dim <= r.dim;
    coord <= r.coord;
    accepted <= r.accepted;
    end_of_event <= r.end_of_event;
    bin <= r.bin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic [CH_W-1:0] pick_channel();
    return ($urandom_range(3) == 0) ? CH_W'($urandom_range(MAX_CHANNELS - 1))
                                    : CH_W'($urandom_range(3));
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? '1 : '0;
    return COORD_W'($urandom_range(2**COORD_W - 1));
  endfunction

  // One event of one to MAX_DIMS samples on one channel; end mark on the last.
  task automatic send_event(output int sent);
    logic [CH_W-1:0]  ch;
    logic             acc;
    logic [DIM_W-1:0] d;
    int               n;
    ch = pick_channel();
    acc = ($urandom_range(9) != 0);
    n = int'($urandom_range(1, MAX_DIMS));
    for (int i = 0; i < n; i++) begin
      d = ($urandom_range(3) == 0) ? DIM_W'($urandom_range(MAX_DIMS - 1)) : DIM_W'(i);
      send_item(make_sample(ch, d, pick_coord(), acc, i == n - 1, 1'b0));
    end
    sent = n;
  endtask

  task automatic send_random_read();
    logic [BIN_W-1:0] b;
    b = ($urandom_range(7) == 0) ? BIN_W'($urandom_range(2**BIN_W - 1))
                                 : BIN_W'($urandom_range(NUM_BINS - 1));
    send_item(make_read(pick_channel(), DIM_W'($urandom_range(MAX_DIMS - 1)), b,
                        $urandom_range(299) == 0, 1'($urandom_range(1))));
  endtask

  task automatic send_noise();
    hist_req_t r;
    r.kind = req_kind_t'($urandom_range(1));
    r.start_batch = ($urandom_range(19) == 0);
    r.channel = CH_W'($urandom_range(2**CH_W - 1));
    r.dim = DIM_W'($urandom_range(2**DIM_W - 1));
    r.coord = COORD_W'($urandom_range(2**COORD_W - 1));
    r.accepted = 1'($urandom_range(1));
    r.end_of_event = 1'($urandom_range(1));
    r.bin = BIN_W'($urandom_range(2**BIN_W - 1));
    send_item(r);
  endtask

  task automatic run_random_items(input int count);
    int sent;
    int n;
    sent = 0;
    while (sent < count) begin
      n = $urandom_range(99);
      if (n < 55) begin
        send_event(n);
        sent += n;
      end else if (n < 90) begin
        send_random_read();
        sent++;
      end else begin
        send_noise();
        sent++;
      end
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(make_read(0, 0, 0, 1'b0, 1'b0));
    send_item(make_sample(0, 0, 16'h0000, 1'b1, 1'b0, 1'b0));
    send_item(make_sample(0, 0, 16'h0000, 1'b1, 1'b0, 1'b0));
    send_item(make_sample(0, 0, 16'hFFFF, 1'b1, 1'b1, 1'b0));
    // Bin count above the event count: the weight saturates at one.
    send_item(make_read(0, 0, 0, 1'b0, 1'b0));
    // A rejected event leaves every count alone, end mark or not.
    send_item(make_sample(0, 7, 16'h8000, 1'b0, 1'b1, 1'b0));
    send_item(make_sample(0, 7, 16'h8000, 1'b1, 1'b1, 1'b0));
    send_item(make_sample(0, 1, 16'h0001, 1'b1, 1'b1, 1'b0));
    // One third and two thirds, truncated.
    send_item(make_read(0, 0, 9, 1'b0, 1'b0));
    send_item(make_read(0, 0, 0, 1'b0, 1'b1));
    // Bins past the last one read as zero.
    send_item(make_read(0, 0, 15, 1'b0, 1'b0));
    send_item(make_read(0, 0, BIN_W'(NUM_BINS), 1'b0, 1'b0));
    // Coordinates on either side of the first bin boundary.
    send_item(make_sample(15, 7, 16'h1999, 1'b1, 1'b0, 1'b0));
    send_item(make_sample(15, 7, 16'h199A, 1'b1, 1'b0, 1'b0));
    send_item(make_read(15, 7, 0, 1'b0, 1'b0));
    send_item(make_read(15, 7, 1, 1'b0, 1'b0));
    send_item(make_read(0, 7, 5, 1'b1, 1'b0));
    send_item(make_sample(3, 2, 16'hCCCD, 1'b1, 1'b1, 1'b1));
    send_item(make_read(3, 2, 8, 1'b0, 1'b0));
    send_item(make_read(0, 0, 0, 1'b0, 1'b0));
  endtask

  // Drives one bin far above its channel's event count so the weight saturates.
  task automatic test_saturation();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 24; i++)
      send_item(make_sample(2, 3, 16'h6666, 1'b1, (i % 8) == 7, 1'b0));
    for (int i = 0; i < 3; i++)
      send_item(make_sample(2, 3, 16'h8000, 1'b1, 1'b0, 1'b0));
    send_item(make_read(2, 3, 3, 1'b0, 1'b0));
    send_item(make_read(2, 3, 5, 1'b0, 1'b0));
    send_item(make_sample(2, 3, 16'h6666, 1'b1, 1'b1, 1'b0));
    send_item(make_read(2, 3, 3, 1'b0, 1'b0));
    send_item(make_read(2, 3, 3, 1'b1, 1'b0));
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_items(ITEMS_PER_PHASE);
    send_idle_pct = 53;
    run_random_items(ITEMS_PER_PHASE);
    send_idle_pct = 0;
    recv_stall_pct = 53;
    run_random_items(ITEMS_PER_PHASE);
    send_idle_pct = 9;
    recv_stall_pct = 9;
    run_random_items(ITEMS_PER_PHASE);
  endtask

  // The sender holds off until every pending read has been answered.
  task automatic test_pause_for_results();
    send_idle_pct = 9;
    recv_stall_pct = 53;
    run_random_items(30);
    in_valid <= 1'b0;
    @(negedge clk);
    while (weights_due.size() != 0) @(negedge clk);
    run_random_items(30);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_saturation();
    test_random_phases();
    test_pause_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (weights_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (weights_due.size() != 0) begin
      $error("%0d read results never arrived", weights_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS adaptive_bin_weight_histogram_core");
    end else begin
      $display("FAIL adaptive_bin_weight_histogram_core");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/abwh_pkg.sv
design/abwh_ctrl.sv
design/abwh_datapath.sv
design/adaptive_bin_weight_histogram_core.sv
sim/adaptive_bin_weight_histogram_core_tb.sv
